// ----- hw/rtl/ordered_set_round_robin_picker_assert.svh -----
// Assertion macros for the round-robin picker checker.
// Depends on nothing; the including file must provide aclk and aresetn.
`ifndef ORDERED_SET_ROUND_ROBIN_PICKER_ASSERT_SVH
`define ORDERED_SET_ROUND_ROBIN_PICKER_ASSERT_SVH

// check outside reset
`define OSRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check at every edge, reset included
`define OSRR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/osrr_pkg.sv -----
// Shared types and constants for the round-robin picker.
// No dependencies.
package osrr_pkg;

    localparam int ID_W     = 8;
    localparam int POS_W    = ID_W + 1;
    localparam int WORD_W   = 16;
    localparam int WBIT_W   = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_SELECT = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SELECTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } state_t;

endpackage

// ----- hw/rtl/osrr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/ordered_set_round_robin_picker.sv -----
// Round-robin picker over a membership bitmap: select, insert and remove commands.
// Depends on osrr_pkg and osrr_ram.
//
// One command is processed at a time; s_tready is high only while the sequencer is idle.
// An empty select, an unused opcode, or an insert or remove of an out-of-range ID goes from
// the transfer straight to the done state. Insert and remove first pass the read and check
// states. A select, or a remove of the member under the cursor, scans the bitmap RAM one
// 16-bit word at a time (address, then check of the registered read data). A select from the
// end mark makes two passes: wrap to the smallest member, then find its successor. The
// sequencer returns to idle when the result is loaded, and the next transfer can then be
// taken. A result still waiting for m_tready holds the sequencer before it loads the next
// result. The bitmap has one valid bit per word, so no clearing pass follows reset.
module ordered_set_round_robin_picker
    import osrr_pkg::*;
#(
    parameter int MAX_IDS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ID_W-1:0]     s_tdata,   // [7:0] member_id
    input  logic [OP_W-1:0]     s_tuser,   // [1:0] opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ID_W-1:0]     m_tdata,   // [7:0] chosen_id
    output logic [STATUS_W-1:0] m_tuser    // [2:0] status
);

    localparam int NUM_IDS   = (MAX_IDS < (1 << ID_W)) ? MAX_IDS : (1 << ID_W);
    localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(NUM_IDS + 1);
    localparam int WSEL_W    = POS_W - WBIT_W;

    state_t state_reg, state_next;

    logic [OP_W-1:0]      op_reg, op_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 first_reg, first_next;
    logic [ID_W-1:0]      cursor_reg, cursor_next;
    logic                 at_end_reg, at_end_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ID_W-1:0]      chosen_reg, chosen_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ID_W-1:0]      m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;
    logic [(1 << WADDR_W)-1:0] word_vld_reg, word_vld_next;
    logic                 rd_vld_reg;

    logic [WSEL_W-1:0]    word_sel;
    logic [WADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]    rd_data;
    logic [WORD_W-1:0]    word_eff;
    logic [WORD_W-1:0]    bit_mask;
    logic [WORD_W-1:0]    scan_bits;
    logic                 hit;
    logic [WBIT_W-1:0]    hit_bit;
    logic [POS_W-1:0]     found;
    logic                 pos_end;
    logic                 cur_bit;
    logic                 id_out;
    logic                 wr_en;
    logic [WORD_W-1:0]    wr_data;
    logic                 s_fire;
    logic                 out_free;

    assign word_sel = pos_reg[POS_W-1:WBIT_W];
    assign rd_addr  = word_sel[WADDR_W-1:0];

    osrr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (rd_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign word_eff  = rd_vld_reg ? rd_data : '0;
    assign bit_mask  = WORD_W'(1) << pos_reg[WBIT_W-1:0];
    assign scan_bits = word_eff & ({WORD_W{1'b1}} << pos_reg[WBIT_W-1:0]);
    assign cur_bit   = |(word_eff & bit_mask);
    assign pos_end   = (pos_reg >= POS_W'(NUM_IDS));
    assign found     = {word_sel, hit_bit};
    assign id_out    = ({1'b0, s_tdata} >= POS_W'(NUM_IDS));
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (scan_bits[i]) begin
                hit     = 1'b1;
                hit_bit = WBIT_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        OP_SELECT: state_next = (cnt_reg == '0) ? S_DONE : S_SCAN_RD;
                        OP_INSERT,
                        OP_REMOVE: state_next = id_out ? S_DONE : S_READ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_READ:  state_next = S_CHECK;
            S_CHECK: begin
                if (op_reg == OP_REMOVE && cur_bit && !at_end_reg
                        && cursor_reg == pos_reg[ID_W-1:0]) begin
                    state_next = S_SCAN_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_RD:  state_next = pos_end ? S_DONE : S_SCAN_CHK;
            S_SCAN_CHK: state_next = (hit && !first_reg) ? S_DONE : S_SCAN_RD;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next       = op_reg;
        pos_next      = pos_reg;
        first_next    = first_reg;
        cursor_next   = cursor_reg;
        at_end_next   = at_end_reg;
        cnt_next      = cnt_reg;
        chosen_next   = chosen_reg;
        status_next   = status_reg;
        word_vld_next = word_vld_reg;
        wr_en         = 1'b0;
        wr_data       = word_eff;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_next     = s_tuser;
                    pos_next    = {1'b0, s_tdata};
                    chosen_next = '0;
                    first_next  = 1'b0;
                    status_next = ST_ABSENT;
                    if (s_tuser == OP_SELECT) begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            status_next = ST_SELECTED;
                            if (at_end_reg) begin
                                first_next = 1'b1;
                                pos_next   = '0;
                            end else begin
                                chosen_next = cursor_reg;
                                pos_next    = {1'b0, cursor_reg} + POS_W'(1);
                            end
                        end
                    end
                end
            end
            S_CHECK: begin
                if (op_reg == OP_INSERT) begin
                    if (cur_bit) begin
                        status_next = ST_PRESENT;
                    end else begin
                        wr_en                  = 1'b1;
                        wr_data                = word_eff | bit_mask;
                        word_vld_next[rd_addr] = 1'b1;
                        cnt_next               = cnt_reg + CNT_W'(1);
                        status_next            = ST_INSERTED;
                    end
                end else if (cur_bit) begin
                    wr_en                  = 1'b1;
                    wr_data                = word_eff & ~bit_mask;
                    word_vld_next[rd_addr] = 1'b1;
                    cnt_next               = cnt_reg - CNT_W'(1);
                    status_next            = ST_REMOVED;
                    pos_next               = pos_reg + POS_W'(1);
                end
            end
            S_SCAN_RD: begin
                if (pos_end) begin
                    at_end_next = 1'b1;
                    cursor_next = '0;
                end
            end
            S_SCAN_CHK: begin
                if (hit) begin
                    if (first_reg) begin
                        chosen_next = found[ID_W-1:0];
                        pos_next    = found + POS_W'(1);
                        first_next  = 1'b0;
                    end else begin
                        cursor_next = found[ID_W-1:0];
                        at_end_next = 1'b0;
                    end
                end else begin
                    pos_next = {word_sel + WSEL_W'(1), {WBIT_W{1'b0}}};
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = chosen_reg;
                    m_tuser_next  = status_reg;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cursor_reg   <= '0;
            at_end_reg   <= 1'b1;
            cnt_reg      <= '0;
            first_reg    <= 1'b0;
            word_vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            at_end_reg   <= at_end_next;
            cnt_reg      <= cnt_next;
            first_reg    <= first_next;
            word_vld_reg <= word_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        chosen_reg  <= chosen_next;
        status_reg  <= status_next;
        rd_vld_reg  <= word_vld_reg[rd_addr];
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hw/rtl/osrr_checker.sv -----
// Port-level assertions for the round-robin picker, bound to the top level.
// Depends on osrr_pkg and ordered_set_round_robin_picker_assert.svh.
`include "ordered_set_round_robin_picker_assert.svh"

module osrr_checker
    import osrr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [ID_W-1:0]     s_tdata,   // [7:0] member_id
    input logic [OP_W-1:0]     s_tuser,   // [1:0] opcode
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [ID_W-1:0]     m_tdata,   // [7:0] chosen_id
    input logic [STATUS_W-1:0] m_tuser    // [2:0] status
);

    `OSRR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `OSRR_ASSERT(a_busy_after_in, s_tvalid && s_tready |=> !s_tready, "ready high right after a transfer")
    `OSRR_ASSERT(a_zero_id, m_tvalid && m_tuser != ST_SELECTED |-> m_tdata == '0, "nonzero id without selection")
    `OSRR_ASSERT(a_status_range, m_tvalid |-> m_tuser <= ST_ABSENT, "status code out of range")
    `OSRR_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind ordered_set_round_robin_picker osrr_checker u_osrr_checker (.*);
